### src/tapd_pkg.sv
`default_nettype none

package tapd_pkg;

    // Field widths
    localparam int POS_W   = 16;             // position fields, mm
    localparam int VEL_W   = 16;             // velocity fields
    localparam int FRAC_W  = 12;             // velocity fraction bits
    localparam int GAIN_W  = 16;             // Q8.8 gains
    localparam int CFG_W   = 16;             // widest config register
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int ERR_W   = POS_W + 1;      // target - position
    localparam int DIFF_W  = ERR_W + 1;      // error change
    localparam int DER_W   = DIFF_W + 4;     // ten times error change
    localparam int PP_W    = GAIN_W + 1 + ERR_W;
    localparam int PD_W    = GAIN_W + 1 + DER_W;
    localparam int SUM_W   = PD_W + 1;
    localparam int VEXT_W  = VEL_W + 1;      // velocity before final saturation

    // |S| above this value always rounds to a magnitude of 2^(VEL_W-1) or more
    localparam int SMAG_W  = 21;
    localparam logic [SUM_W-1:0] S_SAT = SUM_W'(2047969);

    // Velocity scaling: q = floor((4*|S| + 125) / 250), done as (x/2)/125
    localparam int VX_W     = SMAG_W + 2;
    localparam int RV_W     = 23;
    localparam int RV_SHIFT = 29;
    localparam logic [RV_W-1:0] RECIP_V = RV_W'(4294968);   // ceil(2^29 / 125)

    // Slow-down scaling: q = floor((256*|d| + 625) / 1250), done as (x/2)/625
    localparam int SX_W     = 24;
    localparam int RS_W     = 24;
    localparam int RS_SHIFT = 33;
    localparam int SQ_W     = 14;
    localparam logic [RS_W-1:0] RECIP_S = RS_W'(13743896);  // ceil(2^33 / 625)

    // Envelope limits, mm
    localparam logic signed [POS_W-1:0] NEAR_FAR_MM = 16'sd2440;
    localparam logic signed [POS_W-1:0] WALL_MM     = 16'sd10000;
    localparam logic signed [POS_W-1:0] CAM_FAR_MM  = 16'sd2000;
    localparam logic signed [POS_W-1:0] CAM_NEAR_MM = 16'sd1000;

    localparam logic signed [VEXT_W-1:0] VEL_ONE = VEXT_W'(1 << FRAC_W);
    localparam logic signed [VEXT_W-1:0] VEL_MAX = VEXT_W'(32767);
    localparam logic signed [VEXT_W-1:0] VEL_MIN = -VEXT_W'(32768);

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_C = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P_C = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D_C = 3'd5;

    // Zone and limit flags carried down the pipe
    typedef struct packed {
        logic far;
        logic near;
        logic wall;
        logic cam_far;
        logic cam_near;
        logic track;
    } zone_t;

    // PD sum to velocity units, rounded half away from zero
    function automatic logic signed [VEXT_W-1:0] vel_scale(
        input logic signed [SUM_W-1:0] sum
    );
        logic                   neg;
        logic [SUM_W-1:0]       mag;
        logic [SMAG_W-1:0]      clip;
        logic [VX_W-1:0]        x;
        logic [VX_W-2:0]        y;
        logic [VX_W-1+RV_W-1:0] prod;
        logic [VEL_W-1:0]       q;
        neg  = sum[SUM_W-1];
        mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
        clip = (mag > S_SAT) ? SMAG_W'(S_SAT) : mag[SMAG_W-1:0];
        x    = {clip, 2'b00} + VX_W'(125);
        y    = x[VX_W-1:1];
        prod = y * RECIP_V;
        q    = prod[RV_SHIFT +: VEL_W];
        return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // Slow-down speed for a distance in mm, rounded half away from zero
    function automatic logic signed [VEXT_W-1:0] slow_scale(
        input logic signed [ERR_W-1:0] diff
    );
        logic                   neg;
        logic [ERR_W-1:0]       mag;
        logic [SX_W-1:0]        x;
        logic [SX_W-2:0]        y;
        logic [SX_W-1+RS_W-1:0] prod;
        logic [SQ_W-1:0]        q;
        neg  = diff[ERR_W-1];
        mag  = neg ? ERR_W'(-diff) : ERR_W'(diff);
        x    = {mag[POS_W-1:0], 8'h00} + SX_W'(625);
        y    = x[SX_W-1:1];
        prod = y * RECIP_S;
        q    = prod[RS_SHIFT +: SQ_W];
        return neg ? -$signed({3'b000, q}) : $signed({3'b000, q});
    endfunction

    function automatic logic signed [VEXT_W-1:0] clamp_one(
        input logic signed [VEXT_W-1:0] v
    );
        if (v > VEL_ONE) begin
            return VEL_ONE;
        end else if (v < -VEL_ONE) begin
            return -VEL_ONE;
        end
        return v;
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(
        input logic signed [VEXT_W-1:0] v
    );
        if (v > VEL_MAX) begin
            return VEL_MAX[VEL_W-1:0];
        end else if (v < VEL_MIN) begin
            return VEL_MIN[VEL_W-1:0];
        end
        return v[VEL_W-1:0];
    endfunction

endpackage

`default_nettype wire

### src/two_axis_pd_with_safety_envelope_top.sv
// Channel   Dir  tdata (low bit up)                          tuser (low bit up)
// s_        in   position_a_mm, position_b_mm, position_c_mm  encoders_valid,
//                                                            tracking_ok, send_now
// m_        out  velocity_a, velocity_c                      override_a, override_c,
//                                                            protected_stop
// cfg_      in   write enable, index 0..5, 16-bit data
//
// One request per clock while the pipe advances. Four register stages (input,
// PD sum, scaling, result) carry each request to m_tvalid in that order.
// All stages advance together when the result register is empty or taken, so
// s_tready follows m_tready whenever a result is held.
// Synchronous active-low reset clears the pipe, the error history and loads
// the config defaults.
`default_nettype none

module two_axis_pd_with_safety_envelope_top
    import tapd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [47:0]           s_tdata,    // position_a_mm, position_b_mm, position_c_mm
    input  wire logic [2:0]            s_tuser,    // encoders_valid, tracking_ok, send_now

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,    // velocity_a, velocity_c
    output logic [2:0]                 m_tuser,    // override_a, override_c, protected_stop

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    logic pipe_adv;

    // Config registers
    logic signed [POS_W-1:0] target_a_reg, target_c_reg;
    logic [GAIN_W-1:0]       gain_p_a_reg, gain_d_a_reg, gain_p_c_reg, gain_d_c_reg;

    // Error history
    logic signed [ERR_W-1:0] last_err_a_reg, last_err_c_reg;

    // Input stage
    logic                    a_valid_reg;
    logic signed [POS_W-1:0] a_pos_a_reg, a_pos_b_reg, a_pos_c_reg;
    logic                    a_track_reg, a_send_reg;

    // PD sum stage
    logic                    b_valid_reg;
    logic signed [SUM_W-1:0] b_sum_a_reg, b_sum_c_reg;
    logic signed [ERR_W-1:0] b_sd_a_reg, b_sd_c_reg;
    zone_t                   b_zone_reg;

    // Scaling stage
    logic                     c_valid_reg;
    logic signed [VEXT_W-1:0] c_va_reg, c_vc_reg, c_sa_reg, c_sc_reg;
    zone_t                    c_zone_reg;

    // Result register
    logic                    m_valid_reg;
    logic signed [VEL_W-1:0] m_vel_a_reg, m_vel_c_reg;
    logic                    m_ova_reg, m_ovc_reg, m_stop_reg;

    // Whole pipe moves when the result register can take a new value
    assign pipe_adv = !m_valid_reg || m_tready;
    assign s_tready = pipe_adv;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_a_reg <= 16'sd935;
            target_c_reg <= 16'sd379;
            gain_p_a_reg <= 16'd192;
            gain_d_a_reg <= 16'd256;
            gain_p_c_reg <= 16'd384;
            gain_d_c_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TARGET_A: target_a_reg <= $signed(cfg_wdata);
                CFG_TARGET_C: target_c_reg <= $signed(cfg_wdata);
                CFG_GAIN_P_A: gain_p_a_reg <= cfg_wdata;
                CFG_GAIN_D_A: gain_d_a_reg <= cfg_wdata;
                CFG_GAIN_P_C: gain_p_c_reg <= cfg_wdata;
                CFG_GAIN_D_C: gain_d_c_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register; ticks with invalid encoders are dropped here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (pipe_adv) begin
            a_valid_reg <= s_tvalid && s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            a_pos_a_reg <= $signed(s_tdata[15:0]);
            a_pos_b_reg <= $signed(s_tdata[31:16]);
            a_pos_c_reg <= $signed(s_tdata[47:32]);
            a_track_reg <= s_tuser[1];
            a_send_reg  <= s_tuser[2];
        end
    end

    // Errors, derivatives and PD products
    logic signed [ERR_W-1:0]  err_a, err_c;
    logic signed [DIFF_W-1:0] dlt_a, dlt_c;
    logic signed [DER_W-1:0]  der_a, der_c;
    logic signed [PP_W-1:0]   pp_a, pp_c;
    logic signed [PD_W-1:0]   pd_a, pd_c;
    logic signed [SUM_W-1:0]  sum_a_next, sum_c_next;
    logic signed [ERR_W-1:0]  sd_a_next, sd_c_next;
    zone_t                    zone_next;

    assign err_a = ERR_W'(target_a_reg) - ERR_W'(a_pos_a_reg);
    assign err_c = ERR_W'(target_c_reg) - ERR_W'(a_pos_c_reg);
    assign dlt_a = DIFF_W'(err_a) - DIFF_W'(last_err_a_reg);
    assign dlt_c = DIFF_W'(err_c) - DIFF_W'(last_err_c_reg);
    assign der_a = (DER_W'(dlt_a) <<< 3) + (DER_W'(dlt_a) <<< 1);
    assign der_c = (DER_W'(dlt_c) <<< 3) + (DER_W'(dlt_c) <<< 1);
    assign pp_a  = $signed({1'b0, gain_p_a_reg}) * err_a;
    assign pp_c  = $signed({1'b0, gain_p_c_reg}) * err_c;
    assign pd_a  = $signed({1'b0, gain_d_a_reg}) * der_a;
    assign pd_c  = $signed({1'b0, gain_d_c_reg}) * der_c;
    assign sum_a_next = SUM_W'(pp_a) + SUM_W'(pd_a);
    assign sum_c_next = SUM_W'(pp_c) + SUM_W'(pd_c);

    // Slow-down distances and zone flags
    assign sd_a_next = ERR_W'(a_pos_b_reg) - ERR_W'(WALL_MM);
    assign sd_c_next = ERR_W'(a_pos_c_reg) - ERR_W'(CAM_NEAR_MM);

    always_comb begin
        zone_next.far      = a_pos_a_reg > NEAR_FAR_MM;
        zone_next.near     = a_pos_a_reg < NEAR_FAR_MM;
        zone_next.wall     = a_pos_a_reg > WALL_MM;
        zone_next.cam_far  = a_pos_c_reg < CAM_FAR_MM;
        zone_next.cam_near = a_pos_c_reg < CAM_NEAR_MM;
        zone_next.track    = a_track_reg;
    end

    // Error history follows every valid tick, sent or not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_a_reg <= '0;
            last_err_c_reg <= '0;
        end else if (pipe_adv && a_valid_reg) begin
            last_err_a_reg <= err_a;
            last_err_c_reg <= err_c;
        end
    end

    // PD sum register; only ticks that send go on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (pipe_adv) begin
            b_valid_reg <= a_valid_reg && a_send_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            b_sum_a_reg <= sum_a_next;
            b_sum_c_reg <= sum_c_next;
            b_sd_a_reg  <= sd_a_next;
            b_sd_c_reg  <= sd_c_next;
            b_zone_reg  <= zone_next;
        end
    end

    // Scale to velocity units
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (pipe_adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            c_va_reg   <= vel_scale(b_sum_a_reg);
            c_vc_reg   <= vel_scale(b_sum_c_reg);
            c_sa_reg   <= slow_scale(b_sd_a_reg);
            c_sc_reg   <= slow_scale(b_sd_c_reg);
            c_zone_reg <= b_zone_reg;
        end
    end

    // Safety envelope
    logic                     rep_a, rep_c;
    logic signed [VEXT_W-1:0] va_rep, vc_rep, va_env, vc_env;
    logic signed [VEL_W-1:0]  vel_a_next, vel_c_next;

    always_comb begin
        rep_c  = (c_vc_reg < 0) &&
                 ((c_zone_reg.far && c_zone_reg.cam_far) ||
                  (c_zone_reg.near && c_zone_reg.cam_near));
        rep_a  = c_zone_reg.far && c_zone_reg.wall && (c_va_reg > 0);
        vc_rep = rep_c ? c_sc_reg : c_vc_reg;
        va_rep = rep_a ? -c_sa_reg : c_va_reg;
        va_env = c_zone_reg.far ? clamp_one(va_rep) : va_rep;
        vc_env = c_zone_reg.far ? clamp_one(vc_rep) : vc_rep;
        if (c_zone_reg.track) begin
            vel_a_next = sat_vel(va_env);
            vel_c_next = sat_vel(vc_env);
        end else begin
            vel_a_next = '0;
            vel_c_next = '0;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_adv) begin
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            m_vel_a_reg <= vel_a_next;
            m_vel_c_reg <= vel_c_next;
            m_ova_reg   <= rep_a;
            m_ovc_reg   <= rep_c;
            m_stop_reg  <= !c_zone_reg.track;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_vel_c_reg, m_vel_a_reg};
    assign m_tuser  = {m_stop_reg, m_ovc_reg, m_ova_reg};

    // Checks
    ap_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_stop_reg |-> (m_vel_a_reg == 0) && (m_vel_c_reg == 0))
        else $error("protected stop with nonzero velocity");

    ap_far_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && c_zone_reg.far |->
            (va_env <= VEL_ONE) && (va_env >= -VEL_ONE) &&
            (vc_env <= VEL_ONE) && (vc_env >= -VEL_ONE))
        else $error("far zone velocity beyond clamp");

    ap_near_slow: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && c_zone_reg.near && rep_c |-> (vc_rep <= 0))
        else $error("near zone slow-down not toward camera");

    ap_drop_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=> !a_valid_reg)
        else $error("invalid tick entered the pipe");

    ap_hist_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pipe_adv && a_valid_reg) |=> $stable(last_err_a_reg) && $stable(last_err_c_reg))
        else $error("error history changed without a valid tick");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
    import tapd_pkg::*;

    // Envelope limits and scaling, mm and velocity units
    localparam longint ZONE_EDGE_MM  = 2440;
    localparam longint WALL_LIMIT_MM = 10000;
    localparam longint CAM_SLOW_MM   = 2000;
    localparam longint CAM_STOP_MM   = 1000;
    localparam longint UNIT_SPEED    = longint'(1) << 12;
    localparam longint SUM_CAP       = longint'(1) << 40;
    localparam longint PD_DIVISOR    = 256000;
    localparam longint CREEP_DIVISOR = 20000;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;          // pipe depth plus margin
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 212;
    localparam int DIR_ROWS      = 16;

    // Index past the register file, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{
        CFG_TARGET_A, CFG_TARGET_C, CFG_GAIN_P_A, CFG_GAIN_D_A, CFG_GAIN_P_C, CFG_GAIN_D_C
    };

    typedef struct packed {
        logic signed [POS_W-1:0] pos_a;
        logic signed [POS_W-1:0] pos_b;
        logic signed [POS_W-1:0] pos_c;
        logic                    enc_valid;
        logic                    track_ok;
        logic                    send_now;
    } tick_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_a;
        logic signed [VEL_W-1:0] vel_c;
        logic                    ovr_a;
        logic                    ovr_c;
        logic                    stop;
    } cmd_t;

    typedef struct packed {
        tick_t tick;
        logic  pinned;
        cmd_t  want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata   = '0;
    logic [2:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b1;
    logic [31:0]          m_tdata;
    logic [2:0]           m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Typed expectation riding along with the current request
    logic pin_valid = 1'b0;
    cmd_t pin_cmd   = '0;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int error_count     = 0;
    int cycle_count     = 0;

    // Predictor copy of registers and error history
    logic signed [15:0] set_target_a = 16'sd935;
    logic signed [15:0] set_target_c = 16'sd379;
    logic [15:0]        set_kp_a     = 16'd192;
    logic [15:0]        set_kd_a     = 16'd256;
    logic [15:0]        set_kp_c     = 16'd384;
    logic [15:0]        set_kd_c     = 16'd0;
    longint             err_hist_a   = 0;
    longint             err_hist_c   = 0;

    cmd_t pending_cmds [$];

    // Directed rows, run under the reset register values
    dir_row_t dir_rows [DIR_ROWS] = '{
        // on target: zero command
        '{'{16'sd935, 16'sd0, 16'sd379, 1'b1, 1'b1, 1'b1}, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}},
        // encoders invalid: nothing at all
        '{'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        // tracking lost, no override possible
        '{'{16'sd0, 16'sd0, 16'sd379, 1'b1, 1'b0, 1'b1}, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1}},
        // no send, history still moves
        '{'{16'sd1000, 16'sd0, 16'sd500, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        // exactly on the zone edge
        '{'{16'sd2440, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        // far zone, camera slow-down
        '{'{16'sd2441, 16'sd0, 16'sd1999, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        // park far out so the next error change is large and positive
        '{'{16'sh7FFF, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        // past the wall with positive speed
        '{'{16'sd10001, 16'sh7FFF, 16'sd0, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        // near zone, camera slow-down
        '{'{16'sd0, 16'sd0, 16'sd999, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        // override reported, then zeroed by lost tracking
        '{'{16'sd2441, 16'sd0, 16'sd1500, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
        '{'{16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'sd12000, 16'sh8000, 16'sd1000, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'sd935, 16'sd0, 16'sd379, 1'b1, 1'b1, 1'b1}, 1'b0, '0}
    };

    two_axis_pd_with_safety_envelope_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Rounded to nearest, ties away from zero; den > 0
    function automatic longint round_half_away(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint pd_speed(input longint err, input longint prev,
                                        input longint kp, input longint kd);
        longint s;
        s = kp * err + kd * (10 * (err - prev));
        if (s > SUM_CAP) begin
            s = SUM_CAP;
        end else if (s < -SUM_CAP) begin
            s = -SUM_CAP;
        end
        return round_half_away(s * UNIT_SPEED, PD_DIVISOR);
    endfunction

    function automatic longint creep_speed(input longint dist_mm);
        return round_half_away(dist_mm * UNIT_SPEED, CREEP_DIVISOR);
    endfunction

    function automatic longint bound(input longint v, input longint lo, input longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // One control tick: updates the error history, returns 1 when a command is due
    function automatic bit compute_command(input tick_t t, output cmd_t c);
        longint pa, pb, pc, ea, ec, va, vc;
        c = '0;
        if (!t.enc_valid) begin
            return 1'b0;
        end
        pa = t.pos_a;
        pb = t.pos_b;
        pc = t.pos_c;
        ea = longint'(set_target_a) - pa;
        ec = longint'(set_target_c) - pc;
        va = pd_speed(ea, err_hist_a, set_kp_a, set_kd_a);
        vc = pd_speed(ec, err_hist_c, set_kp_c, set_kd_c);
        err_hist_a = ea;
        err_hist_c = ec;
        if (!t.send_now) begin
            return 1'b0;
        end
        if (pa > ZONE_EDGE_MM) begin
            if (pc < CAM_SLOW_MM && vc < 0) begin
                vc = creep_speed(pc - CAM_STOP_MM);
                c.ovr_c = 1'b1;
            end
            if (pa > WALL_LIMIT_MM && va > 0) begin
                va = -creep_speed(pb - WALL_LIMIT_MM);
                c.ovr_a = 1'b1;
            end
            va = bound(va, -UNIT_SPEED, UNIT_SPEED);
            vc = bound(vc, -UNIT_SPEED, UNIT_SPEED);
        end else if (pa < ZONE_EDGE_MM) begin
            if (pc < CAM_STOP_MM && vc < 0) begin
                vc = creep_speed(pc - CAM_STOP_MM);
                c.ovr_c = 1'b1;
            end
        end
        if (!t.track_ok) begin
            va = 0;
            vc = 0;
            c.stop = 1'b1;
        end
        c.vel_a = VEL_W'(bound(va, -32768, 32767));
        c.vel_c = VEL_W'(bound(vc, -32768, 32767));
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Predict on accepted requests, check accepted commands, watch the clock
    always @(posedge aclk) begin
        cmd_t c;
        cmd_t exp_cmd;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TARGET_A: set_target_a = cfg_wdata;
                    CFG_TARGET_C: set_target_c = cfg_wdata;
                    CFG_GAIN_P_A: set_kp_a = cfg_wdata;
                    CFG_GAIN_D_A: set_kd_a = cfg_wdata;
                    CFG_GAIN_P_C: set_kp_c = cfg_wdata;
                    CFG_GAIN_D_C: set_kd_c = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (compute_command(tick_t'({s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                                             s_tuser[0], s_tuser[1], s_tuser[2]}), c))
                begin
                    pending_cmds.push_back(pin_valid ? pin_cmd : c);
                end
            end
            if (m_tvalid && m_tready) begin
                if (pending_cmds.size() == 0) begin
                    $error("command with none pending: tdata %h tuser %b", m_tdata, m_tuser);
                    error_count++;
                end else begin
                    exp_cmd = pending_cmds.pop_front();
                    check_field("velocity_a", exp_cmd.vel_a, $signed(m_tdata[15:0]));
                    check_field("velocity_c", exp_cmd.vel_c, $signed(m_tdata[31:16]));
                    check_field("override_a", exp_cmd.ovr_a, m_tuser[0]);
                    check_field("override_c", exp_cmd.ovr_c, m_tuser[1]);
                    check_field("protected_stop", exp_cmd.stop, m_tuser[2]);
                end
            end
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one request after random idle cycles, return once it is taken
    task automatic send_tick(input tick_t t, input logic pinned, input cmd_t want);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {t.pos_c, t.pos_b, t.pos_a};
        s_tuser   <= {t.send_now, t.track_ok, t.enc_valid};
        pin_valid <= pinned;
        pin_cmd   <= want;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    // Stop sending and wait for every pending command, optionally letting the pipe empty
    task automatic drain_commands(input bit settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) begin
            @(posedge aclk);
        end
        if (settle) begin
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end
    endtask

    task automatic apply_settings(input int ph);
        logic [CFG_W-1:0] vals [6];
        case (ph)
            0: vals = '{16'($urandom_range(0, 4000)), 16'($urandom_range(0, 3000)),
                        16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                        16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024))};
            1: vals = '{16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            2: vals = '{16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
            3: vals = '{16'd15000, 16'(-2000), 16'd256, 16'd512, 16'd256, 16'd256};
            4: vals = '{16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom)};
            5: vals = '{16'd935, 16'd379, 16'd192, 16'd256, 16'd384, 16'd0};
            6: vals = '{16'h7FFF, 16'h8000, 16'd16, 16'd4096, 16'd16, 16'd4096};
            default: vals = '{16'($urandom_range(9000, 14000)), 16'($urandom_range(0, 2500)),
                              16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048)),
                              16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048))};
        endcase
        for (int i = 0; i < 6; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= vals[i];
        end
        @(negedge aclk);
        cfg_index <= CFG_SPARE;
        cfg_wdata <= 16'($urandom);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly smooth motion around a center, with jumps, edges and extremes mixed in
    function automatic logic signed [15:0] pick_position(input logic signed [15:0] prev,
                                                         input int center);
        int edges [4] = '{2440, 10000, 2000, 1000};
        int rails [4] = '{-32768, 32767, 0, -1};
        case ($urandom_range(0, 9))
            0, 1:    return 16'($urandom);
            2:       return 16'(edges[$urandom_range(0, 3)] + $urandom_range(0, 6) - 3);
            3:       return 16'(rails[$urandom_range(0, 3)]);
            4:       return 16'(center + $urandom_range(0, 400) - 200);
            default: return 16'(int'(prev) + $urandom_range(0, 60) - 30);
        endcase
    endfunction

    initial begin
        tick_t t;
        t = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_tick(dir_rows[i].tick, dir_rows[i].pinned, dir_rows[i].want);
        end
        drain_commands(1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            apply_settings(ph);
            case (ph % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            @(negedge aclk);
            t.pos_a = set_target_a;
            t.pos_b = 16'sd10000;
            t.pos_c = set_target_c;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                t.pos_a     = pick_position(t.pos_a, set_target_a);
                t.pos_b     = pick_position(t.pos_b, int'(WALL_LIMIT_MM));
                t.pos_c     = pick_position(t.pos_c, set_target_c);
                t.enc_valid = ($urandom_range(0, 9) != 0);
                t.track_ok  = ($urandom_range(0, 7) != 0);
                t.send_now  = ($urandom_range(0, 3) != 0);
                send_tick(t, 1'b0, '0);
                // hold off once mid-phase until the pipe has delivered everything
                if (ph == 2 && n == PHASE_ITEMS / 2) begin
                    drain_commands(1'b0);
                end
            end
            drain_commands(1'b1);
        end

        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
